### design/grmc_pkg.sv
// Shared types and codes for the guest region map checker.
// Holds the request, result and chain token structs; no dependencies.
`default_nettype none

package grmc_pkg;

  typedef enum logic [1:0] {
    FN_MAP   = 2'd0,
    FN_INIT  = 2'd1,
    FN_READ  = 2'd2,
    FN_WRITE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_WRAPS     = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_OVERLAP   = 3'd4,
    ST_FULL      = 3'd5,
    ST_DENIED    = 3'd6
  } status_e;

  typedef struct packed {
    func_e       func;
    logic [63:0] address;
    logic [63:0] length;
    logic [2:0]  permissions;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  region_index;
    logic [63:0] offset;
    logic [4:0]  region_count;
  } res_t;

  // Request state as it walks down the row of region cells.
  typedef struct packed {
    func_e       func;
    logic [63:0] address;
    logic [63:0] addr_end;     // address + length, low 64 bits
    logic        wrap;         // address + length reaches 2^64
    logic [2:0]  permissions;
    status_e     status;       // map status so far
    logic        found;        // an access found its first containing region
    logic        granted;      // that region allows the access
    logic        written;      // a map was stored in a cell
    logic [63:0] hit_base;
  } tok_t;

endpackage

`default_nettype wire

### design/guest_region_map_checker.sv
// Top level of the guest region map checker: entry stage, row of region cells,
// result register. Depends on grmc_pkg and grmc_cell.
//
//   Port group   Direction  Handshake                 Payload
//   in_*         input      in_valid_i / in_stall_o   req_t in_req_i
//   out_*        output     out_valid_o / out_stall_i res_t out_res_o
//   cfg_*        input      cfg_we_i                  cfg_wdata_i (max region size)
//
// A request passes from its transfer to its result through the entry register,
// the register of each region cell in the row, and the result register.
// The next request is taken the cycle after a result enters the result register.
// A stalled result holds the row; the request waits in the last cell.
// Reset clears the region count and sets the size limit to all ones.
`default_nettype none

module guest_region_map_checker import grmc_pkg::*; #(
  parameter int MAX_REGIONS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire req_t  in_req_i,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output res_t       out_res_o,
  input  wire logic  cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  logic [63:0]      max_size_q;
  logic [CNT_W-1:0] used_count_q;
  logic             busy_q;
  logic             out_valid_q;
  res_t             out_res_q, res_d;
  logic             vld0_q;
  tok_t             tok0_q, tok0_d;
  logic             accept;
  logic             out_load;
  logic             en;
  logic [64:0]      sum;
  logic [CNT_W-1:0] cnt_after;

  logic             vld [0:MAX_REGIONS];
  tok_t             tok [0:MAX_REGIONS];
  logic [IDX_W-1:0] idx [0:MAX_REGIONS];
  logic [CNT_W-1:0] cnt [0:MAX_REGIONS];

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign out_load   = vld[MAX_REGIONS] && (!out_valid_q || !out_stall_i);
  assign en         = !vld[MAX_REGIONS] || out_load;

  // Entry stage: the wide add and the early map checks.
  always_comb begin
    sum                = {1'b0, in_req_i.address} + {1'b0, in_req_i.length};
    tok0_d             = '0;
    tok0_d.func        = in_req_i.func;
    tok0_d.address     = in_req_i.address;
    tok0_d.addr_end    = sum[63:0];
    tok0_d.wrap        = sum[64];
    tok0_d.permissions = in_req_i.permissions;
    if (in_req_i.length == 64'd0) begin
      tok0_d.status = ST_EMPTY;
    end else if (sum[64]) begin
      tok0_d.status = ST_WRAPS;
    end else if (in_req_i.length > max_size_q) begin
      tok0_d.status = ST_TOO_LARGE;
    end else begin
      tok0_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q   <= '1;
      used_count_q <= '0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      vld0_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_size_q <= cfg_wdata_i;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
      if (accept) begin
        vld0_q <= 1'b1;
      end else if (en) begin
        vld0_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q  <= 1'b1;
        used_count_q <= cnt_after;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok0_q <= tok0_d;
    end
    if (out_load) begin
      out_res_q <= res_d;
    end
  end

  assign vld[0] = vld0_q;
  assign tok[0] = tok0_q;
  assign idx[0] = '0;
  assign cnt[0] = used_count_q;

  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    grmc_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[g]),
      .tok_i  (tok[g]),
      .idx_i  (idx[g]),
      .cnt_i  (cnt[g]),
      .vld_o  (vld[g+1]),
      .tok_o  (tok[g+1]),
      .idx_o  (idx[g+1]),
      .cnt_o  (cnt[g+1])
    );
  end

  assign cnt_after = cnt[MAX_REGIONS] + CNT_W'(tok[MAX_REGIONS].written);

  // Result of the request leaving the last cell.
  always_comb begin
    res_d              = '0;
    res_d.region_count = 5'(cnt_after);
    if (tok[MAX_REGIONS].func == FN_MAP) begin
      if (tok[MAX_REGIONS].status != ST_OK) begin
        res_d.status = tok[MAX_REGIONS].status;
      end else if (tok[MAX_REGIONS].written) begin
        res_d.status       = ST_OK;
        res_d.region_index = 4'(idx[MAX_REGIONS]);
      end else begin
        res_d.status = ST_FULL;
      end
    end else if (tok[MAX_REGIONS].found && tok[MAX_REGIONS].granted) begin
      res_d.status       = ST_OK;
      res_d.region_index = 4'(idx[MAX_REGIONS]);
      res_d.offset       = tok[MAX_REGIONS].address - tok[MAX_REGIONS].hit_base;
    end else begin
      res_d.status = ST_DENIED;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  logic [MAX_REGIONS:0] vld_vec;
  for (genvar g = 0; g <= MAX_REGIONS; g++) begin : g_vld
    assign vld_vec[g] = vld[g];
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld_vec))
    else $error("more than one request in the cell row");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count_q <= CNT_W'(MAX_REGIONS))
    else $error("region count above table size");

  a_accept_empty_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (vld_vec == '0) && !out_load)
    else $error("request taken while the row is busy");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && tok[MAX_REGIONS].written) |=> used_count_q == $past(used_count_q) + 1'b1)
    else $error("stored map did not advance the region count");

  a_busy_tracks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_vec != '0) |-> busy_q)
    else $error("request in the row while input side is open");

endmodule

`default_nettype wire

### design/grmc_cell.sv
// One region cell of the checker row: holds one region and updates the token.
// Depends on grmc_pkg.
`default_nettype none

module grmc_cell import grmc_pkg::*; #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire tok_t             tok_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire logic [CNT_W-1:0] cnt_i,
  output logic                  vld_o,
  output tok_t                  tok_o,
  output logic      [IDX_W-1:0] idx_o,
  output logic      [CNT_W-1:0] cnt_o
);

  logic [63:0]      base_q;
  logic [63:0]      end_q;
  logic [2:0]       perm_q;
  logic             vld_q;
  tok_t             tok_q, tok_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q;
  logic             held;
  logic             wr;
  logic             is_map;

  assign is_map = (tok_i.func == FN_MAP);
  // Regions fill the row from the front, so a cell is in use below the count.
  assign held   = (CNT_W'(IDX) < cnt_i);
  assign wr     = vld_i && is_map && (tok_i.status == ST_OK) && !tok_i.written &&
                  (CNT_W'(IDX) == cnt_i);

  always_comb begin
    tok_d = tok_i;
    idx_d = idx_i;
    if (held) begin
      if (is_map) begin
        if (tok_i.status == ST_OK && base_q < tok_i.addr_end && tok_i.address < end_q) begin
          tok_d.status = ST_OVERLAP;
        end
      end else if (!tok_i.found && !tok_i.wrap && tok_i.address >= base_q &&
                   tok_i.addr_end <= end_q) begin
        tok_d.found    = 1'b1;
        tok_d.granted  = (tok_i.func == FN_INIT) ||
                         (tok_i.func == FN_READ && perm_q[0]) ||
                         (tok_i.func == FN_WRITE && perm_q[1]);
        tok_d.hit_base = base_q;
        idx_d          = IDX_W'(IDX);
      end
    end
    if (wr) begin
      tok_d.written = 1'b1;
      idx_d         = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
      idx_q <= idx_d;
      cnt_q <= cnt_i;
    end
    if (en_i && wr) begin
      base_q <= tok_i.address;
      end_q  <= tok_i.addr_end;
      perm_q <= tok_i.permissions;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;
  assign idx_o = idx_q;
  assign cnt_o = cnt_q;

endmodule

`default_nettype wire
